// ----- hw/rtl/thresholded_window_mean_filter_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the thresholded window mean filter core
// Concurrent checks that simulation keeps and synthesis drops.
// ----------------------------------------------------------------------------
`ifndef THRESHOLDED_WINDOW_MEAN_FILTER_CORE_DEFINES_SVH
`define THRESHOLDED_WINDOW_MEAN_FILTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clock and off during reset.
`define TWMF_ASSERT_IMP(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("twmf assertion failed");
// Next-cycle implication, sampled on clock and off during reset.
`define TWMF_ASSERT_NXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("twmf assertion failed");
`else
`define TWMF_ASSERT_IMP(lbl, pre, post)
`define TWMF_ASSERT_NXT(lbl, pre, post)
`endif

`endif

// ----- hw/rtl/twmf_pkg.sv -----
// ----------------------------------------------------------------------------
// twmf_pkg
// Sizes, register indexes and codes shared by the window mean filter files.
// ----------------------------------------------------------------------------
package twmf_pkg;

   // Map and window limits.
   localparam int MAX_SIDE   = 256;
   localparam int MAX_RADIUS = 7;

   // Field widths of the items and registers.
   localparam int COORD_W = 8;
   localparam int SIDE_W  = 9;
   localparam int RAD_W   = 3;
   localparam int HGT_W   = 24;
   localparam int PIX_W   = 32;
   localparam int CHAN_W  = 8;

   // Storage and arithmetic widths.
   localparam int ADDR_W    = $clog2(MAX_SIDE * MAX_SIDE);
   localparam int WIN_MAX   = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
   localparam int CNT_W     = $clog2(WIN_MAX + 1);
   localparam int SUM_W     = HGT_W + CNT_W;
   localparam int CSUM_W    = CHAN_W + CNT_W;
   localparam int DIV_W     = SUM_W;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   // Stream and register port widths.
   localparam int REQ_DATA_W = 48;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIM_LIMIT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VOID_HGT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_COLS   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_ROWS   = 3'd5;

   // Register reset values.
   localparam logic [RAD_W-1:0]  RST_RADIUS    = 3'd1;
   localparam logic [HGT_W-1:0]  RST_SIM_LIMIT = 24'd1000;
   localparam logic [HGT_W-1:0]  RST_VOID_HGT  = 24'd0;
   localparam logic [SIDE_W-1:0] RST_MAP_SIDE  = 9'd256;

   // Request kinds carried in tuser.
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

endpackage

// ----- hw/rtl/thresholded_window_mean_filter_core.sv -----
// ----------------------------------------------------------------------------
// thresholded_window_mean_filter_core
// Pixel map with a thresholded (sigma) window mean or a box mean per query.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the req_ stream: tuser selects a pixel write or a query, and
// tdata carries column, row and the pixel word. Every item yields exactly one
// item on the rsp_ stream: zero for writes and off-map queries, the filtered
// word for queries, with tuser marking query answers. Registers are written on
// the csr_ channel, which is always ready; the user must write them only while
// the block is idle, which the block itself does not enforce. A write or an
// off-map query goes from idle straight to the response state. A query reads
// its centre and then its N window pixels from the map RAM, one per cycle
// (N at most 225). The shared restoring divider, one quotient bit per cycle,
// then runs once in height mode and once per channel in color mode. One item
// is worked on at a time. The result sits in an output register, so the next
// item is accepted while it waits; a stalled receiver only holds the following
// result back. Reset restores the register defaults and empties the output;
// map contents stay undefined until written and no clearing pass runs.
// ----------------------------------------------------------------------------
`include "thresholded_window_mean_filter_core_defines.svh"

module thresholded_window_mean_filter_core
   import twmf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request stream.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // col [7:0], row [15:8], pixel_word [47:16]
   input  logic                  req_tuser,  // req_type [0]
   // Result stream.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PIX_W-1:0]      rsp_tdata,  // filtered_word [31:0]
   output logic                  rsp_tuser,  // was_query [0]
   // Register write channel.
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CENTRE,
      ST_SCAN,
      ST_DRAIN,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_RESP
   } state_type;

   // Control and configuration registers.
   state_type         state_ff, state_in;
   logic              color_mode_ff, color_mode_in;
   logic [RAD_W-1:0]  radius_ff, radius_in;
   logic [HGT_W-1:0]  limit_ff, limit_in;
   logic [HGT_W-1:0]  void_ff, void_in;
   logic [SIDE_W-1:0] cols_ff, cols_in;
   logic [SIDE_W-1:0] rows_ff, rows_in;
   logic              pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [SIDE_W-1:0]       x1_ff, x1_in, x2_ff, x2_in;
   logic [SIDE_W-1:0]       y1_ff, y1_in, y2_ff, y2_in;
   logic [SIDE_W-1:0]       xx_ff, xx_in, yy_ff, yy_in;
   logic [PIX_W-1:0]        centre_ff, centre_in;
   logic signed [SUM_W-1:0] hsum_ff, hsum_in;
   logic [CSUM_W-1:0]       csum_ff [4];
   logic [CSUM_W-1:0]       csum_in [4];
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [1:0]              chan_ff, chan_in;
   logic [PIX_W-1:0]        res_ff, res_in;
   logic                    wq_ff, wq_in;
   logic [PIX_W-1:0]        rsp_data_ff, rsp_data_in;
   logic                    rsp_user_ff, rsp_user_in;

   // Map RAM and divider connections.
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [PIX_W-1:0]  ram_rdata;
   logic              div_start, div_done;
   logic [DIV_W-1:0]  div_dividend, div_quotient;

   // Decoded request and effective configuration.
   logic [COORD_W-1:0]      req_col, req_row;
   logic [PIX_W-1:0]        req_pix;
   logic                    req_accept, on_map;
   logic [SIDE_W-1:0]       cols_eff, rows_eff, r_eff;
   logic [SIDE_W-1:0]       xc, yc, xe, ye;
   logic signed [HGT_W-1:0] v_hgt, c_hgt;
   logic signed [HGT_W:0]   diff;
   logic [HGT_W:0]          adiff;
   logic                    qualifies;
   logic [HGT_W-1:0]        qmag;

   function automatic logic [ADDR_W-1:0] pix_addr(input logic [SIDE_W-1:0] r,
                                                  input logic [SIDE_W-1:0] c);
      return ADDR_W'(r) * ADDR_W'(MAX_SIDE) + ADDR_W'(c);
   endfunction

   twmf_ram #(
      .DATA_W (PIX_W),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_pix),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   twmf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_col    = req_tdata[7:0];
   assign req_row    = req_tdata[15:8];
   assign req_pix    = req_tdata[47:16];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Map size and radius clamped into their legal ranges.
   always_comb begin
      if (cols_ff == '0) begin
         cols_eff = SIDE_W'(1);
      end else if (int'(cols_ff) > MAX_SIDE) begin
         cols_eff = SIDE_W'(MAX_SIDE);
      end else begin
         cols_eff = cols_ff;
      end
      if (rows_ff == '0) begin
         rows_eff = SIDE_W'(1);
      end else if (int'(rows_ff) > MAX_SIDE) begin
         rows_eff = SIDE_W'(MAX_SIDE);
      end else begin
         rows_eff = rows_ff;
      end
      if (int'(radius_ff) > MAX_RADIUS) begin
         r_eff = SIDE_W'(MAX_RADIUS);
      end else begin
         r_eff = SIDE_W'(radius_ff);
      end
   end

   // Window bounds of the requested pixel, clipped at the map edges.
   assign xc     = SIDE_W'(req_col);
   assign yc     = SIDE_W'(req_row);
   assign xe     = xc + r_eff;
   assign ye     = yc + r_eff;
   assign on_map = (xc < cols_eff) && (yc < rows_eff);
   assign x1_in  = (state_ff == ST_IDLE) ? ((xc > r_eff) ? xc - r_eff : '0) : x1_ff;
   assign y1_in  = (state_ff == ST_IDLE) ? ((yc > r_eff) ? yc - r_eff : '0) : y1_ff;
   assign x2_in  = (state_ff == ST_IDLE) ?
                   ((xe > cols_eff - SIDE_W'(1)) ? cols_eff - SIDE_W'(1) : xe) : x2_ff;
   assign y2_in  = (state_ff == ST_IDLE) ?
                   ((ye > rows_eff - SIDE_W'(1)) ? rows_eff - SIDE_W'(1) : ye) : y2_ff;

   // Height test of the pixel returned by the RAM against the centre.
   assign v_hgt     = signed'(ram_rdata[HGT_W-1:0]);
   assign c_hgt     = signed'(centre_ff[HGT_W-1:0]);
   assign diff      = {v_hgt[HGT_W-1], v_hgt} - {c_hgt[HGT_W-1], c_hgt};
   assign adiff     = diff[HGT_W] ? unsigned'(-diff) : unsigned'(diff);
   assign qualifies = (adiff < {1'b0, limit_ff}) && (ram_rdata[HGT_W-1:0] != void_ff);

   // Divider operand: height magnitude or the current colour channel sum.
   assign div_dividend = color_mode_ff ? DIV_W'(csum_ff[chan_ff])
                                       : (hsum_ff[SUM_W-1] ? unsigned'(-hsum_ff)
                                                           : unsigned'(hsum_ff));
   assign qmag = div_quotient[HGT_W-1:0];

   // Register writes from the configuration channel.
   always_comb begin
      color_mode_in = color_mode_ff;
      radius_in     = radius_ff;
      limit_in      = limit_ff;
      void_in       = void_ff;
      cols_in       = cols_ff;
      rows_in       = rows_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_COLOR_MODE: color_mode_in = csr_data[0];
            CSR_RADIUS:     radius_in     = csr_data[RAD_W-1:0];
            CSR_SIM_LIMIT:  limit_in      = csr_data[HGT_W-1:0];
            CSR_VOID_HGT:   void_in       = csr_data[HGT_W-1:0];
            CSR_MAP_COLS:   cols_in       = csr_data[SIDE_W-1:0];
            CSR_MAP_ROWS:   rows_in       = csr_data[SIDE_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: centre read, window scan, division and result hand-off.
   always_comb begin
      state_in     = state_ff;
      xx_in        = xx_ff;
      yy_in        = yy_ff;
      centre_in    = centre_ff;
      hsum_in      = hsum_ff;
      csum_in      = csum_ff;
      cnt_in       = cnt_ff;
      chan_in      = chan_ff;
      res_in       = res_ff;
      wq_in        = wq_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      pend_in      = (state_ff == ST_SCAN);
      ram_we       = 1'b0;
      ram_waddr    = pix_addr(yc, xc);
      ram_raddr    = pix_addr(yy_ff, xx_ff);
      div_start    = 1'b0;

      // Accumulate the pixel read in the previous cycle.
      if (pend_ff) begin
         if (color_mode_ff) begin
            for (int k = 0; k < 4; k++) begin
               csum_in[k] = csum_ff[k] + CSUM_W'(ram_rdata[k*CHAN_W +: CHAN_W]);
            end
            cnt_in = cnt_ff + CNT_W'(1);
         end else if (qualifies) begin
            hsum_in = hsum_ff + SUM_W'(v_hgt);
            cnt_in  = cnt_ff + CNT_W'(1);
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            ram_raddr = pix_addr(yc, xc);
            if (req_accept) begin
               wq_in  = req_tuser;
               res_in = '0;
               if (req_tuser == REQ_WRITE) begin
                  ram_we   = on_map;
                  state_in = ST_RESP;
               end else if (on_map) begin
                  state_in = ST_CENTRE;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_CENTRE: begin
            centre_in = ram_rdata;
            xx_in     = x1_ff;
            yy_in     = y1_ff;
            hsum_in   = '0;
            cnt_in    = '0;
            for (int k = 0; k < 4; k++) begin
               csum_in[k] = '0;
            end
            if (!color_mode_ff && (ram_rdata[HGT_W-1:0] == void_ff)) begin
               res_in   = {{(PIX_W-HGT_W){1'b0}}, ram_rdata[HGT_W-1:0]};
               state_in = ST_RESP;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (xx_ff == x2_ff) begin
               xx_in = x1_ff;
               if (yy_ff == y2_ff) begin
                  state_in = ST_DRAIN;
               end else begin
                  yy_in = yy_ff + SIDE_W'(1);
               end
            end else begin
               xx_in = xx_ff + SIDE_W'(1);
            end
         end
         ST_DRAIN: begin
            chan_in  = '0;
            res_in   = '0;
            state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            if (!color_mode_ff && (cnt_ff == '0)) begin
               res_in   = {{(PIX_W-HGT_W){1'b0}}, centre_ff[HGT_W-1:0]};
               state_in = ST_RESP;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV_RUN;
            end
         end
         ST_DIV_RUN: begin
            if (div_done) begin
               if (color_mode_ff) begin
                  res_in[{chan_ff, 3'b000} +: CHAN_W] = div_quotient[CHAN_W-1:0];
                  chan_in = chan_ff + 2'd1;
                  state_in = (chan_ff == 2'd3) ? ST_RESP : ST_DIV_LOAD;
               end else begin
                  res_in   = {{(PIX_W-HGT_W){1'b0}},
                              (hsum_ff[SUM_W-1] ? -qmag : qmag)};
                  state_in = ST_RESP;
               end
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               rsp_user_in  = wq_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State, configuration and output registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         color_mode_ff <= 1'b0;
         radius_ff     <= RST_RADIUS;
         limit_ff      <= RST_SIM_LIMIT;
         void_ff       <= RST_VOID_HGT;
         cols_ff       <= RST_MAP_SIDE;
         rows_ff       <= RST_MAP_SIDE;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         color_mode_ff <= color_mode_in;
         radius_ff     <= radius_in;
         limit_ff      <= limit_in;
         void_ff       <= void_in;
         cols_ff       <= cols_in;
         rows_ff       <= rows_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      x1_ff       <= x1_in;
      x2_ff       <= x2_in;
      y1_ff       <= y1_in;
      y2_ff       <= y2_in;
      xx_ff       <= xx_in;
      yy_ff       <= yy_in;
      centre_ff   <= centre_in;
      hsum_ff     <= hsum_in;
      csum_ff     <= csum_in;
      cnt_ff      <= cnt_in;
      chan_ff     <= chan_in;
      res_ff      <= res_in;
      wq_ff       <= wq_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Checks on the sequencer and the result path.
   `TWMF_ASSERT_NXT(a_one_item_at_a_time, req_tvalid && req_tready, !req_tready)
   `TWMF_ASSERT_IMP(a_write_result_zero, rsp_tvalid && !rsp_tuser, rsp_tdata == 0)
   `TWMF_ASSERT_IMP(a_read_during_scan, pend_ff, state_ff == ST_SCAN || state_ff == ST_DRAIN)
   `TWMF_ASSERT_IMP(a_div_done_expected, div_done, state_ff == ST_DIV_RUN)

endmodule

// ----- hw/rtl/twmf_ram.sv -----
// ----------------------------------------------------------------------------
// twmf_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module twmf_ram #(
   parameter int DATA_W = 32,
   parameter int ADDR_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/twmf_div.sv -----
// ----------------------------------------------------------------------------
// twmf_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module twmf_div
   import twmf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [CNT_W-1:0]     div_ff, div_in;
   logic [CNT_W:0]       trial;
   logic                 fits;

   // One shift-subtract step per busy cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      fits    = trial >= {1'b0, div_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_W - 1);
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? CNT_W'(trial - {1'b0, div_ff}) : trial[CNT_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
